@@ rtl/core/ara_pkg.sv @@
// ara_pkg: types and constants shared by the alert repeat aggregator.
// Holds the channel payload structs, slot entry, FSM state and ctrl/datapath
// command and status bundles. No dependencies.
`default_nettype none

package ara_pkg;

	// configuration register indexes
	localparam logic CFG_CRITICAL = 1'b0;
	localparam logic CFG_WINDOW   = 1'b1;

	localparam logic [2:0]  CRIT_RESET   = 3'd4;
	localparam logic [15:0] WINDOW_RESET = 16'd60;

	// item kinds and result kinds
	localparam logic KIND_ALERT   = 1'b0;
	localparam logic KIND_FLUSH   = 1'b1;
	localparam logic RES_DECISION = 1'b0;
	localparam logic RES_FLUSH    = 1'b1;

	// summaries reported by one flush at most
	localparam int unsigned OUT_LIMIT = 64;
	localparam int unsigned NW        = $clog2(OUT_LIMIT + 1);
	typedef logic [NW-1:0] sum_cnt_t;

	typedef struct packed {
		logic        kind;
		logic [2:0]  threat;
		logic [63:0] name_hi;
		logic [63:0] name_lo;
		logic [31:0] reason_code;
		logic [31:0] now_seconds;
	} item_t;

	typedef struct packed {
		logic        result_kind;
		logic        emit;
		logic        has_summary;
		logic [63:0] out_name_hi;
		logic [63:0] out_name_lo;
		logic [31:0] out_reason;
		logic [31:0] repeat_count;
		logic [31:0] elapsed_seconds;
		logic [31:0] suppressed_total;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [63:0] name_hi;
		logic [63:0] name_lo;
		logic [31:0] reason;
		logic [31:0] start;
		logic [31:0] count;
	} slot_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ASCAN,
		ST_ADONE,
		ST_FSCAN,
		ST_FEND
	} state_t;

	typedef struct packed {
		logic start;       // latch item, clear per-item tracking
		logic alert_step;  // record free slot / match at current index
		logic adv;         // move scan index on
		logic commit;      // write slot, emit decision
		logic flush_free;  // clear used bit at current index
		logic flush_summ;  // bank a summary for current slot
		logic flush_end;   // send closing flush transaction
	} cmd_t;

	typedef struct packed {
		logic kind_flush;
		logic critical;
		logic hit;
		logic used;
		logic expired;
		logic multi;
		logic last;
		logic out_free;
		logic pend_valid;
		logic limit;
	} status_t;

endpackage

`default_nettype wire

@@ rtl/core/ara_ctrl.sv @@
// ara_ctrl: sequencing FSM of the alert repeat aggregator.
// Drives ara_pkg::cmd_t into the datapath from ara_pkg::status_t; uses ara_pkg.
`default_nettype none

module ara_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire ara_pkg::status_t status,
	output ara_pkg::cmd_t         cmd
);

	ara_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ara_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			ara_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.start = 1'b1;
					if (status.kind_flush) begin
						state_d = ara_pkg::ST_FSCAN;
					end else if (status.critical) begin
						state_d = ara_pkg::ST_ADONE;
					end else begin
						state_d = ara_pkg::ST_ASCAN;
					end
				end
			end
			ara_pkg::ST_ASCAN: begin
				cmd.alert_step = 1'b1;
				if (status.hit || status.last) begin
					state_d = ara_pkg::ST_ADONE;
				end else begin
					cmd.adv = 1'b1;
				end
			end
			ara_pkg::ST_ADONE: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ara_pkg::ST_IDLE;
				end
			end
			ara_pkg::ST_FSCAN: begin
				if (status.used && status.expired && status.multi) begin
					if (status.limit) begin
						// summary budget spent: leave this and later slots alone
						state_d = ara_pkg::ST_FEND;
					end else if (!status.pend_valid || status.out_free) begin
						cmd.flush_summ = 1'b1;
						cmd.flush_free = 1'b1;
						cmd.adv        = 1'b1;
						if (status.last) begin
							state_d = ara_pkg::ST_FEND;
						end
					end
				end else begin
					cmd.flush_free = status.used && status.expired;
					cmd.adv        = 1'b1;
					if (status.last) begin
						state_d = ara_pkg::ST_FEND;
					end
				end
			end
			ara_pkg::ST_FEND: begin
				if (status.out_free) begin
					cmd.flush_end = 1'b1;
					state_d       = ara_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ara_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/ara_dp.sv @@
// ara_dp: datapath of the alert repeat aggregator: slot table memory, used bits,
// scan index, config registers, summary holding register and output register.
// Uses ara_pkg types; controlled by ara_ctrl.
`default_nettype none

module ara_dp #(
	parameter int SLOTS = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [15:0]      cfg_data,
	input  wire ara_pkg::item_t   item,
	output ara_pkg::result_t      result,
	output logic                  result_valid,
	input  wire logic             result_stall,
	input  wire ara_pkg::cmd_t    cmd,
	output ara_pkg::status_t      status
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [2:0]  crit_q;
	logic [15:0] win_q;

	ara_pkg::item_t       item_q;
	logic [IW-1:0]        idx_q;
	logic                 free_found_q;
	logic [IW-1:0]        free_idx_q;
	logic                 match_q;
	logic [IW-1:0]        match_idx_q;
	logic [31:0]          upd_start_q;
	logic [31:0]          upd_count_q;
	logic                 emit_q;
	logic [SLOTS-1:0]     used_q;
	logic [31:0]          sum_q;
	ara_pkg::sum_cnt_t    n_q;
	ara_pkg::result_t     pend_q;
	logic                 pend_valid_q;
	ara_pkg::result_t     out_q;
	logic                 out_valid_q;

	ara_pkg::slot_entry_t mem [SLOTS];
	ara_pkg::slot_entry_t rd_q;

	logic [31:0]          elapsed;
	logic                 expired;
	logic                 key_eq;
	logic                 used;
	logic                 last;
	logic                 out_free;
	logic [IW-1:0]        nxt;
	logic [IW-1:0]        rd_addr;
	logic [31:0]          add;
	logic [32:0]          sum_w;
	logic [31:0]          sum_new;
	logic [31:0]          cnt_inc;
	logic                 wr_en;
	logic [IW-1:0]        wr_idx;
	ara_pkg::slot_entry_t wr_ent;
	ara_pkg::result_t     summ;
	ara_pkg::result_t     out_d;
	logic                 out_load;

	assign elapsed  = item_q.now_seconds - rd_q.start;
	assign expired  = elapsed >= {16'd0, win_q};
	assign key_eq   = (rd_q.name_hi == item_q.name_hi) && (rd_q.name_lo == item_q.name_lo)
		&& (rd_q.reason == item_q.reason_code);
	assign used     = used_q[idx_q];
	assign last     = idx_q == IW'(SLOTS - 1);
	assign nxt      = last ? '0 : idx_q + 1'b1;
	// read one slot ahead while the scan moves, so rd_q holds the entry of the new index
	assign rd_addr  = cmd.adv ? nxt : idx_q;
	assign out_free = !out_valid_q || !result_stall;

	assign add     = rd_q.count - 32'd1;
	assign sum_w   = {1'b0, sum_q} + {1'b0, add};
	assign sum_new = sum_w[32] ? '1 : sum_w[31:0];
	assign cnt_inc = (rd_q.count == '1) ? rd_q.count : rd_q.count + 32'd1;

	always_comb begin
		status            = '0;
		status.kind_flush = item.kind == ara_pkg::KIND_FLUSH;
		status.critical   = item.threat >= crit_q;
		status.hit        = used && key_eq;
		status.used       = used;
		status.expired    = expired;
		status.multi      = rd_q.count > 32'd1;
		status.last       = last;
		status.out_free   = out_free;
		status.pend_valid = pend_valid_q;
		status.limit      = n_q == ara_pkg::sum_cnt_t'(ara_pkg::OUT_LIMIT);
	end

	// slot write on commit: refresh a matched slot or fill the lowest free one
	assign wr_en  = cmd.commit && (match_q || free_found_q);
	assign wr_idx = match_q ? match_idx_q : free_idx_q;
	always_comb begin
		wr_ent.name_hi = item_q.name_hi;
		wr_ent.name_lo = item_q.name_lo;
		wr_ent.reason  = item_q.reason_code;
		wr_ent.start   = match_q ? upd_start_q : item_q.now_seconds;
		wr_ent.count   = match_q ? upd_count_q : 32'd1;
	end

	always_comb begin
		summ                  = '0;
		summ.result_kind      = ara_pkg::RES_FLUSH;
		summ.has_summary      = 1'b1;
		summ.out_name_hi      = rd_q.name_hi;
		summ.out_name_lo      = rd_q.name_lo;
		summ.out_reason       = rd_q.reason;
		summ.repeat_count     = rd_q.count;
		summ.elapsed_seconds  = elapsed;
		summ.suppressed_total = sum_new;
	end

	always_comb begin
		out_d    = '0;
		out_load = 1'b0;
		if (cmd.commit) begin
			out_load          = 1'b1;
			out_d.result_kind = ara_pkg::RES_DECISION;
			out_d.emit        = match_q ? emit_q : 1'b1;
			out_d.last        = 1'b1;
		end else if (cmd.flush_summ && pend_valid_q) begin
			// a newer summary exists, so the banked one is not the last
			out_load = 1'b1;
			out_d    = pend_q;
		end else if (cmd.flush_end) begin
			out_load = 1'b1;
			if (pend_valid_q) begin
				out_d      = pend_q;
				out_d.last = 1'b1;
			end else begin
				out_d.result_kind      = ara_pkg::RES_FLUSH;
				out_d.suppressed_total = sum_q;
				out_d.last             = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_ent;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crit_q       <= ara_pkg::CRIT_RESET;
			win_q        <= ara_pkg::WINDOW_RESET;
			idx_q        <= '0;
			free_found_q <= 1'b0;
			match_q      <= 1'b0;
			used_q       <= '0;
			sum_q        <= '0;
			n_q          <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == ara_pkg::CFG_CRITICAL) begin
					crit_q <= cfg_data[2:0];
				end else begin
					win_q <= cfg_data;
				end
			end
			if (cmd.start) begin
				idx_q        <= '0;
				free_found_q <= 1'b0;
				match_q      <= 1'b0;
				n_q          <= '0;
				pend_valid_q <= 1'b0;
			end else if (cmd.commit || cmd.flush_end) begin
				idx_q <= '0;
			end else if (cmd.adv) begin
				idx_q <= nxt;
			end
			if (cmd.alert_step) begin
				if (!used && !free_found_q) begin
					free_found_q <= 1'b1;
				end
				if (used && key_eq) begin
					match_q <= 1'b1;
				end
			end
			if (wr_en && !match_q) begin
				used_q[free_idx_q] <= 1'b1;
			end
			if (cmd.flush_free) begin
				used_q[idx_q] <= 1'b0;
			end
			if (cmd.flush_summ) begin
				sum_q        <= sum_new;
				n_q          <= n_q + 1'b1;
				pend_valid_q <= 1'b1;
			end
			if (cmd.flush_end) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			item_q <= item;
		end
		if (cmd.alert_step) begin
			if (!used && !free_found_q) begin
				free_idx_q <= idx_q;
			end
			if (used && key_eq) begin
				match_idx_q <= idx_q;
				emit_q      <= expired;
				upd_start_q <= expired ? item_q.now_seconds : rd_q.start;
				upd_count_q <= expired ? 32'd1 : cnt_inc;
			end
		end
		if (cmd.flush_summ) begin
			pend_q <= summ;
		end
		if (out_load) begin
			out_q <= out_d;
		end
	end

	assign result       = out_q;
	assign result_valid = out_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/alert_repeat_aggregator_top.sv @@
// alert_repeat_aggregator_top: windowed repeat counting of alerts in a slot table.
// Instantiates ara_ctrl and ara_dp; payload types from ara_pkg.
//
//   channel   handshake                    payload
//   item      item_valid / item_stall      ara_pkg::item_t
//   result    result_valid / result_stall  ara_pkg::result_t
//   config    cfg_we (no wait)             cfg_index, cfg_data[15:0]
//
// Alert at/above critical level: decided without a scan. Other alerts scan the
// slot table one slot a cycle through its single read port, stopping at the first
// match. A flush walks slots to the last or until the summary budget is spent,
// held up by result stalls while a summary waits. Reset clears the used bits in
// one step; slot contents are not cleared and no sweep follows reset. Items are
// taken only while the engine is idle; a finished result waits in the output reg.
`default_nettype none

module alert_repeat_aggregator_top #(
	parameter int SLOTS = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [15:0]      cfg_data,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire ara_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output ara_pkg::result_t      result
);

	ara_pkg::cmd_t    cmd;
	ara_pkg::status_t status;

	ara_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	ara_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.result       (result),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.status       (status)
	);

endmodule

`default_nettype wire

@@ test/tb_alert_repeat_aggregator_top.sv @@
// Self-checking testbench for alert_repeat_aggregator_top: directed and random
// alert/flush traffic with random idling on both channels, checked against a local
// model of the slot table. Depends on ara_pkg and the RTL under rtl/core.
module tb_alert_repeat_aggregator_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS    = 64;
	localparam int KEYS     = 66;   // two more than the table holds
	localparam int POOL     = 12;   // keys reused by the random mixes
	localparam int SETTLE   = 4;
	localparam int LIMIT    = 2000000;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [15:0]       cfg_data;
	logic              item_valid;
	logic              item_stall;
	ara_pkg::item_t    item_bus;
	logic              result_valid;
	logic              result_stall;
	ara_pkg::result_t  result_bus;

	alert_repeat_aggregator_top #(.SLOTS(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item_bus),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result_bus)
	);

	// local copy of the dedup table and its registers
	bit          tbl_used[SLOTS];
	logic [63:0] tbl_hi[SLOTS];
	logic [63:0] tbl_lo[SLOTS];
	logic [31:0] tbl_reason[SLOTS];
	logic [31:0] tbl_start[SLOTS];
	logic [31:0] tbl_count[SLOTS];
	logic [31:0] supp_total = '0;
	logic [2:0]  crit_lvl = ara_pkg::CRIT_RESET;
	logic [15:0] win_s = ara_pkg::WINDOW_RESET;

	ara_pkg::result_t results_due[$];

	logic [63:0] key_hi[KEYS];
	logic [63:0] key_lo[KEYS];
	logic [31:0] key_rs[KEYS];
	logic [31:0] wall = '0;

	bit calm = 1'b0;
	int stall_left = 0;
	int errors = 0;
	int cycles = 0;
	int n_alerts = 0;
	int n_flushes = 0;
	int n_results = 0;
	int n_summaries = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				results_due.size());
			$display("alert_repeat_aggregator_top: mismatch");
			$finish;
		end
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 9) < 7)
			return $urandom_range(1, 3);
		return $urandom_range(5, 20);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else begin
			result_stall <= 1'b0;
			if (!calm && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	// Works out the results one transaction causes and advances the table.
	task automatic dedup_table_step(input ara_pkg::item_t it);
		int i;
		int free_idx;
		int n_summ;
		logic hit;
		logic stop;
		logic have_held;
		logic [31:0] age;
		logic [31:0] add;
		logic [32:0] sum;
		ara_pkg::result_t r;
		ara_pkg::result_t held;
		r = '0;
		held = '0;
		if (it.kind == ara_pkg::KIND_ALERT) begin
			n_alerts++;
			r.result_kind = ara_pkg::RES_DECISION;
			r.emit = 1'b1;
			r.last = 1'b1;
			if (it.threat < crit_lvl) begin
				free_idx = -1;
				hit = 1'b0;
				for (i = 0; i < SLOTS && !hit; i++) begin
					if (!tbl_used[i]) begin
						if (free_idx < 0)
							free_idx = i;
					end else if (tbl_hi[i] == it.name_hi && tbl_lo[i] == it.name_lo &&
							tbl_reason[i] == it.reason_code) begin
						hit = 1'b1;
						age = it.now_seconds - tbl_start[i];
						if (age >= {16'h0, win_s}) begin
							tbl_start[i] = it.now_seconds;
							tbl_count[i] = 32'd1;
						end else begin
							if (tbl_count[i] != '1)
								tbl_count[i]++;
							r.emit = 1'b0;
						end
					end
				end
				// full table: decision still emits, nothing stored
				if (!hit && free_idx >= 0) begin
					tbl_used[free_idx] = 1'b1;
					tbl_count[free_idx] = 32'd1;
					tbl_start[free_idx] = it.now_seconds;
					tbl_hi[free_idx] = it.name_hi;
					tbl_lo[free_idx] = it.name_lo;
					tbl_reason[free_idx] = it.reason_code;
				end
			end
			results_due.push_back(r);
		end else begin
			n_flushes++;
			have_held = 1'b0;
			n_summ = 0;
			stop = 1'b0;
			for (i = 0; i < SLOTS && !stop; i++) begin
				age = it.now_seconds - tbl_start[i];
				if (tbl_used[i] && age >= {16'h0, win_s}) begin
					if (tbl_count[i] > 32'd1) begin
						if (n_summ >= ara_pkg::OUT_LIMIT) begin
							stop = 1'b1;
						end else begin
							add = tbl_count[i] - 32'd1;
							sum = {1'b0, supp_total} + {1'b0, add};
							supp_total = sum[32] ? '1 : sum[31:0];
							if (have_held)
								results_due.push_back(held);
							held = '0;
							held.result_kind = ara_pkg::RES_FLUSH;
							held.has_summary = 1'b1;
							held.out_name_hi = tbl_hi[i];
							held.out_name_lo = tbl_lo[i];
							held.out_reason = tbl_reason[i];
							held.repeat_count = tbl_count[i];
							held.elapsed_seconds = age;
							held.suppressed_total = supp_total;
							have_held = 1'b1;
							n_summ++;
						end
					end
					if (!stop)
						tbl_used[i] = 1'b0;
				end
			end
			if (!have_held) begin
				held.result_kind = ara_pkg::RES_FLUSH;
				held.suppressed_total = supp_total;
			end
			held.last = 1'b1;
			results_due.push_back(held);
		end
	endtask

	task automatic check_field(input string fname, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0d ns: %s expected %h, got %h", $time, fname, want, got);
		end
	endtask

	always @(posedge clk) begin
		ara_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			n_results++;
			if (results_due.size() == 0) begin
				errors++;
				$display("%0d ns: result %h arrived with none expected, got %h",
					$time, '0, result_bus);
			end else begin
				want = results_due.pop_front();
				if (want.has_summary)
					n_summaries++;
				check_field("result_kind", want.result_kind, result_bus.result_kind);
				check_field("emit", want.emit, result_bus.emit);
				check_field("has_summary", want.has_summary, result_bus.has_summary);
				check_field("out_name_hi", want.out_name_hi, result_bus.out_name_hi);
				check_field("out_name_lo", want.out_name_lo, result_bus.out_name_lo);
				check_field("out_reason", want.out_reason, result_bus.out_reason);
				check_field("repeat_count", want.repeat_count, result_bus.repeat_count);
				check_field("elapsed_seconds", want.elapsed_seconds,
					result_bus.elapsed_seconds);
				check_field("suppressed_total", want.suppressed_total,
					result_bus.suppressed_total);
				check_field("last", want.last, result_bus.last);
			end
		end
	end

	function automatic ara_pkg::item_t make_item(input logic kind, input logic [2:0] thr,
			input int key, input logic [31:0] now);
		ara_pkg::item_t it;
		it.kind = kind;
		it.threat = thr;
		it.now_seconds = now;
		if (key < 0) begin
			it.name_hi = {$urandom, $urandom};
			it.name_lo = {$urandom, $urandom};
			it.reason_code = $urandom;
		end else begin
			it.name_hi = key_hi[key];
			it.name_lo = key_lo[key];
			it.reason_code = key_rs[key];
		end
		return it;
	endfunction

	task automatic scramble_keys();
		int k;
		for (k = 0; k < KEYS; k++) begin
			key_hi[k] = {$urandom, $urandom};
			key_lo[k] = {$urandom, $urandom};
			key_rs[k] = $urandom;
		end
	endtask

	// One transaction on the item channel; valid stays up when no gap follows.
	task automatic send_item(input ara_pkg::item_t it);
		int gap;
		item_bus <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		dedup_table_step(it);
		gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic await_idle();
		item_valid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_register(input logic idx, input logic [15:0] val);
		await_idle();
		cfg_index <= idx;
		cfg_data <= val;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == ara_pkg::CFG_CRITICAL)
			crit_lvl = val[2:0];
		else
			win_s = val;
	endtask

	// Reset register values: repeat, critical bypass, window expiry across the
	// 32-bit wrap, flush with and without summaries, reason-only key difference.
	task automatic test_directed();
		logic [31:0] t0;
		calm = 1'b0;
		t0 = 32'hFFFF_FFD0;
		key_hi[1] = '1;
		key_lo[1] = '0;
		key_rs[1] = '1;
		key_hi[2] = '0;
		key_lo[2] = '1;
		key_rs[2] = '0;
		key_hi[3] = key_hi[2];
		key_lo[3] = key_lo[2];
		key_rs[3] = 32'd1;
		send_item(make_item(ara_pkg::KIND_ALERT, 3'd0, 0, t0));
		send_item(make_item(ara_pkg::KIND_ALERT, 3'd3, 0, t0 + 32'd10));
		send_item(make_item(ara_pkg::KIND_ALERT, 3'd4, 0, t0 + 32'd11));
		send_item(make_item(ara_pkg::KIND_ALERT, 3'd7, 0, t0 + 32'd12));
		send_item(make_item(ara_pkg::KIND_ALERT, 3'd1, 0, t0 + 32'd59));
		send_item(make_item(ara_pkg::KIND_FLUSH, 3'd0, -1, t0 + 32'd59));
		send_item(make_item(ara_pkg::KIND_FLUSH, 3'd7, -1, t0 + 32'd60));
		send_item(make_item(ara_pkg::KIND_ALERT, 3'd2, 0, t0 + 32'd61));
		send_item(make_item(ara_pkg::KIND_ALERT, 3'd2, 0, t0 + 32'd121));
		send_item(make_item(ara_pkg::KIND_ALERT, 3'd0, 1, t0 + 32'd121));
		send_item(make_item(ara_pkg::KIND_ALERT, 3'd3, 2, t0 + 32'd122));
		send_item(make_item(ara_pkg::KIND_ALERT, 3'd3, 2, t0 + 32'd123));
		send_item(make_item(ara_pkg::KIND_ALERT, 3'd0, 3, t0 + 32'd123));
		send_item(make_item(ara_pkg::KIND_FLUSH, 3'd0, -1, t0 + 32'd400));
		send_item(make_item(ara_pkg::KIND_FLUSH, 3'd0, -1, t0 + 32'd400));
		send_item(make_item(ara_pkg::KIND_ALERT, 3'd0, 4, 32'hFFFF_FFFF));
		send_item(make_item(ara_pkg::KIND_ALERT, 3'd0, 4, 32'h0));
		send_item(make_item(ara_pkg::KIND_FLUSH, 3'd0, -1, 32'd58));
		send_item(make_item(ara_pkg::KIND_FLUSH, 3'd0, -1, 32'd59));
		await_idle();
		wall = 32'd1000;
	endtask

	// Fill every slot plus two overflow keys, repeat all of them in shuffled
	// order, then one flush drains the whole table as summaries.
	task automatic test_full_table();
		int order[KEYS];
		int j;
		int k;
		int tmp;
		logic [31:0] base;
		set_register(ara_pkg::CFG_WINDOW, 16'd0);
		send_item(make_item(ara_pkg::KIND_FLUSH, 3'($urandom), -1, wall));
		set_register(ara_pkg::CFG_CRITICAL, {13'($urandom), 3'd7});
		set_register(ara_pkg::CFG_WINDOW, 16'hFFFF);
		scramble_keys();
		base = wall;
		for (k = 0; k < KEYS; k++) begin
			order[k] = k;
			send_item(make_item(ara_pkg::KIND_ALERT, 3'($urandom_range(0, 6)), k,
				base + k));
		end
		for (k = KEYS - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		for (j = 0; j < KEYS; j++)
			send_item(make_item(ara_pkg::KIND_ALERT, 3'($urandom_range(0, 6)), order[j],
				base + 32'd100 + j));
		wall = base + 32'd70000;
		send_item(make_item(ara_pkg::KIND_FLUSH, 3'($urandom), -1, wall));
		send_item(make_item(ara_pkg::KIND_FLUSH, 3'($urandom), -1, wall));
		await_idle();
	endtask

	// Mostly repeats of a small key set on an advancing clock, with flushes,
	// random-key noise and occasional jumps of the time base.
	task automatic test_random_mix(input logic [2:0] crit, input logic [15:0] win,
			input int count);
		int n;
		int pick;
		logic [31:0] step;
		ara_pkg::item_t it;
		set_register(ara_pkg::CFG_CRITICAL, {13'($urandom), crit});
		set_register(ara_pkg::CFG_WINDOW, win);
		for (n = 0; n < count; n++) begin
			if (n % 10 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 19) == 0)
				await_idle();
			case ($urandom_range(0, 9))
				6, 7:    step = $urandom_range(0, int'(win) + 1);
				8:       step = {16'h0, win} - 32'($urandom_range(0, 1));
				9:       step = $urandom;
				default: step = $urandom_range(0, 3);
			endcase
			wall += step;
			pick = $urandom_range(0, 19);
			if (pick < 2)
				it = make_item(ara_pkg::KIND_FLUSH, 3'($urandom), -1, wall);
			else if (pick < 4)
				it = make_item(ara_pkg::KIND_ALERT, 3'($urandom), -1, $urandom);
			else
				it = make_item(ara_pkg::KIND_ALERT, 3'($urandom),
					$urandom_range(0, POOL - 1), wall);
			send_item(it);
		end
		await_idle();
		calm = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= ara_pkg::CFG_CRITICAL;
		cfg_data <= '0;
		item_valid <= 1'b0;
		item_bus <= '0;
		result_stall <= 1'b0;
		scramble_keys();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_mix(3'd7, 16'd1, 20);
		test_full_table();
		test_random_mix(3'd0, 16'hFFFF, 20);
		test_random_mix(3'd2, 16'd0, 20);
		test_random_mix(3'($urandom_range(1, 6)), 16'($urandom_range(2, 300)), 20);

		await_idle();
		repeat (SLOTS + 8) @(posedge clk);
		$display("covered %0d alerts and %0d flushes, %0d results checked (%0d summaries)",
			n_alerts, n_flushes, n_results, n_summaries);
		$display("critical levels 4/7/0/2/random, windows 60/1/65535/0/random, full table");
		if (errors == 0)
			$display("alert_repeat_aggregator_top: match");
		else
			$display("alert_repeat_aggregator_top: mismatch");
		$finish;
	end

endmodule
